// ===== hdl/kse_pkg.sv =====
// ----------------------------------------------------------------------------
// kse_pkg
// Shared types, register indexes, mode codes and small decode helpers for the
// keyboard scan event generator.
// ----------------------------------------------------------------------------
package kse_pkg;

   localparam int WORD_W = 32;

   // Configuration register indexes.
   localparam logic [2:0] CSR_INTERFACE_MODE    = 3'd0;
   localparam logic [2:0] CSR_SCAN_ENABLE       = 3'd1;
   localparam logic [2:0] CSR_ROW_COUNT         = 3'd2;
   localparam logic [2:0] CSR_COLUMN_COUNT      = 3'd3;
   localparam logic [2:0] CSR_MATRIX_LOW_ACTIVE = 3'd4;
   localparam logic [2:0] CSR_DIRECT_LINE_COUNT = 3'd5;
   localparam logic [2:0] CSR_DIRECT_LOW_ACTIVE = 3'd6;

   // Interface modes.
   localparam logic [1:0] MODE_MATRIX = 2'd0;
   localparam logic [1:0] MODE_DIRECT = 2'd1;
   localparam logic [1:0] MODE_I2C    = 2'd2;
   localparam logic [1:0] MODE_PS2    = 2'd3;

   localparam logic [7:0] NO_POSITION      = 8'hFF;
   localparam logic [7:0] PS2_BREAK_PREFIX = 8'hF0;
   localparam logic [7:0] DIRECT_CODE_BASE = 8'h80;

   typedef struct packed {
      logic [1:0] interface_mode;
      logic       scan_enable;
      logic [4:0] row_count;
      logic [4:0] column_count;
      logic       matrix_low_active;
      logic [5:0] direct_line_count;
      logic       direct_low_active;
   } cfg_type;

   typedef struct packed {
      logic       key_pressed;
      logic [7:0] key_row;
      logic [7:0] key_col;
      logic [7:0] scan_code;
      logic       last_of_run;
   } event_type;

   // Mask of the low count bits of a word; 32 or more gives all ones.
   function automatic logic [WORD_W-1:0] low_mask(input logic [5:0] count);
      logic [WORD_W-1:0] m;
      if (count >= 6'd32) begin
         m = '1;
      end else begin
         m = (32'h1 << count[4:0]) - 32'h1;
      end
      return m;
   endfunction

   // Quotient by ten through a reciprocal multiply, exact for 7-bit values.
   function automatic logic [3:0] div10(input logic [6:0] v);
      logic [14:0] p;
      p = {8'b0, v} * 15'd205;
      return p[14:11];
   endfunction

   function automatic logic [3:0] rem10(input logic [6:0] v);
      logic [6:0] t;
      t = v - ({3'b0, div10(v)} * 7'd10);
      return t[3:0];
   endfunction

endpackage

// ===== hdl/kse_ram.sv =====
// ----------------------------------------------------------------------------
// kse_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module kse_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/kse_cfg.sv =====
// ----------------------------------------------------------------------------
// kse_cfg
// Configuration register file, written through the csr_ transfer channel.
// ----------------------------------------------------------------------------
module kse_cfg
   import kse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_INTERFACE_MODE:    cfg_in.interface_mode    = csr_wdata[1:0];
            CSR_SCAN_ENABLE:       cfg_in.scan_enable       = csr_wdata[0];
            CSR_ROW_COUNT:         cfg_in.row_count         = csr_wdata[4:0];
            CSR_COLUMN_COUNT:      cfg_in.column_count      = csr_wdata[4:0];
            CSR_MATRIX_LOW_ACTIVE: cfg_in.matrix_low_active = csr_wdata[0];
            CSR_DIRECT_LINE_COUNT: cfg_in.direct_line_count = csr_wdata[5:0];
            CSR_DIRECT_LOW_ACTIVE: cfg_in.direct_low_active = csr_wdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interface_mode    <= MODE_MATRIX;
         cfg_ff.scan_enable       <= 1'b1;
         cfg_ff.row_count         <= 5'd16;
         cfg_ff.column_count      <= 5'd16;
         cfg_ff.matrix_low_active <= 1'b0;
         cfg_ff.direct_line_count <= 6'd32;
         cfg_ff.direct_low_active <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// ===== hdl/kse_engine.sv =====
// ----------------------------------------------------------------------------
// kse_engine
// Sequencer around the row memory: reads the stored row, writes the new one
// back, then walks changed bits into the result register one position per
// cycle while it has room. Also decodes the single-byte i2c and ps2 events.
// ----------------------------------------------------------------------------
module kse_engine
   import kse_pkg::*;
#(
   parameter int MAX_ROWS     = 16,
   parameter int MAX_COLS     = 16,
   parameter int DIRECT_LINES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_raw_sample,
   input  logic [3:0]  req_row_index,
   input  logic [63:0] req_sample_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_key_pressed,
   output logic [7:0]  rsp_key_row,
   output logic [7:0]  rsp_key_col,
   output logic [7:0]  rsp_scan_code,
   output logic [63:0] rsp_event_time,
   output logic [31:0] rsp_events_so_far,
   output logic        rsp_last_of_run
);

   localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_LOAD = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [31:0]         raw_ff;
   logic [3:0]          row_ff;
   logic [63:0]         time_ff;
   logic [WORD_W-1:0]   work_s_ff, work_s_in;
   logic [WORD_W-1:0]   work_chg_ff, work_chg_in;
   logic [3:0]          work_row_ff, work_row_in;
   logic                work_direct_ff, work_direct_in;
   logic [4:0]          idx_ff, idx_in;
   logic [MAX_ROWS-1:0] row_valid_ff, row_valid_in;
   logic [DIRECT_LINES-1:0] direct_store_ff, direct_store_in;
   logic                pending_ff, pending_in;
   logic [31:0]         total_ff, total_in;
   logic                rsp_valid_ff, rsp_valid_in;
   event_type           ev_ff;
   logic [63:0]         rsp_time_ff;
   logic [31:0]         rsp_count_ff;

   logic                accept;
   logic                drop;
   logic                slot_free;
   logic                emit;
   event_type           ev;
   logic [4:0]          rows_eff;
   logic [4:0]          cols_eff;
   logic [5:0]          lines_eff;
   logic [WORD_W-1:0]   cols_mask;
   logic [WORD_W-1:0]   lines_mask;
   logic [MAX_COLS-1:0] ram_rd_data;
   logic [MAX_COLS-1:0] old_row;
   logic [15:0]         s16;
   logic [MAX_COLS-1:0] new_row;
   logic [WORD_W-1:0]   mat_chg;
   logic [WORD_W-1:0]   s32;
   logic [WORD_W-1:0]   old_direct;
   logic [WORD_W-1:0]   dir_chg;
   logic [WORD_W-1:0]   tmp_row;
   logic [7:0]          in_byte;
   logic [6:0]          code7;
   logic [6:0]          code_m1;
   logic [WORD_W-1:0]   chg_clear;
   logic                ram_wr_en;

   assign rows_eff  = (cfg.row_count > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : cfg.row_count;
   assign cols_eff  = (cfg.column_count > 5'(MAX_COLS)) ? 5'(MAX_COLS)
                                                        : cfg.column_count;
   assign lines_eff = (cfg.direct_line_count > 6'(DIRECT_LINES)) ? 6'(DIRECT_LINES)
                                                                 : cfg.direct_line_count;
   assign cols_mask  = low_mask({1'b0, cols_eff});
   assign lines_mask = low_mask(lines_eff);

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign drop      = !cfg.scan_enable ||
                      ((cfg.interface_mode == MODE_MATRIX) &&
                       ({1'b0, req_row_index} >= rows_eff));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // The row is read at accept and written back in the following cycle;
   // the next read can only come after the sequencer returns to idle, so a
   // read never overlaps a write to the same row.
   assign ram_wr_en = (state_ff == S_LOAD) && (cfg.interface_mode == MODE_MATRIX);

   kse_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (row_ff[ROW_AW-1:0]),
      .wr_data (new_row),
      .rd_en   (accept),
      .rd_addr (req_row_index[ROW_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // New sample against stored state.
   always_comb begin
      old_row = row_valid_ff[row_ff[ROW_AW-1:0]] ? ram_rd_data : '0;
      if (cfg.matrix_low_active) begin
         s16 = ~raw_ff[15:0] & cols_mask[15:0];
      end else begin
         s16 = raw_ff[15:0];
      end
      new_row = s16[MAX_COLS-1:0];
      tmp_row = '0;
      tmp_row[MAX_COLS-1:0] = new_row ^ old_row;
      mat_chg = tmp_row & cols_mask;

      if (cfg.direct_low_active) begin
         s32 = ~raw_ff & lines_mask;
      end else begin
         s32 = raw_ff;
      end
      old_direct = '0;
      old_direct[DIRECT_LINES-1:0] = direct_store_ff;
      dir_chg = (s32 ^ old_direct) & lines_mask;

      in_byte = raw_ff[7:0];
      code7   = in_byte[6:0];
      code_m1 = code7 - 7'd1;
   end

   always_comb begin
      state_in        = state_ff;
      work_s_in       = work_s_ff;
      work_chg_in     = work_chg_ff;
      work_row_in     = work_row_ff;
      work_direct_in  = work_direct_ff;
      idx_in          = idx_ff;
      row_valid_in    = row_valid_ff;
      direct_store_in = direct_store_ff;
      pending_in      = pending_ff;
      emit            = 1'b0;
      ev              = '0;
      chg_clear       = work_chg_ff & ~(32'h1 << idx_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept && !drop) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            case (cfg.interface_mode)
               MODE_MATRIX: begin
                  work_s_in      = {16'b0, s16};
                  work_chg_in    = mat_chg;
                  work_row_in    = row_ff;
                  work_direct_in = 1'b0;
                  idx_in         = '0;
                  row_valid_in[row_ff[ROW_AW-1:0]] = 1'b1;
                  state_in       = (mat_chg != '0) ? S_SCAN : S_IDLE;
               end
               MODE_DIRECT: begin
                  work_s_in       = s32;
                  work_chg_in     = dir_chg;
                  work_row_in     = row_ff;
                  work_direct_in  = 1'b1;
                  idx_in          = '0;
                  direct_store_in = s32[DIRECT_LINES-1:0];
                  state_in        = (dir_chg != '0) ? S_SCAN : S_IDLE;
               end
               MODE_I2C: begin
                  ev.key_pressed = in_byte[7];
                  ev.key_row     = (code7 != '0) ? {4'b0, div10(code_m1)} : NO_POSITION;
                  ev.key_col     = (code7 != '0) ? {4'b0, rem10(code_m1)} : NO_POSITION;
                  ev.scan_code   = {1'b0, code7};
                  ev.last_of_run = 1'b1;
                  if (in_byte == '0) begin
                     state_in = S_IDLE;
                  end else if (slot_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  ev.key_pressed = !pending_ff;
                  ev.key_row     = NO_POSITION;
                  ev.key_col     = NO_POSITION;
                  ev.scan_code   = in_byte;
                  ev.last_of_run = 1'b1;
                  if (in_byte == PS2_BREAK_PREFIX) begin
                     pending_in = 1'b1;
                     state_in   = S_IDLE;
                  end else if (slot_free) begin
                     emit       = 1'b1;
                     pending_in = 1'b0;
                     state_in   = S_IDLE;
                  end
               end
            endcase
         end
         S_SCAN: begin
            ev.key_pressed = work_s_ff[idx_ff];
            ev.key_row     = work_direct_ff ? NO_POSITION : {4'b0, work_row_ff};
            ev.key_col     = {3'b0, idx_ff};
            ev.scan_code   = work_direct_ff ? (DIRECT_CODE_BASE | {3'b0, idx_ff})
                                            : {work_row_ff, idx_ff[3:0]};
            ev.last_of_run = (chg_clear == '0);
            if (work_chg_ff[idx_ff]) begin
               if (slot_free) begin
                  emit        = 1'b1;
                  work_chg_in = chg_clear;
                  idx_in      = idx_ff + 5'd1;
                  if (chg_clear == '0) begin
                     state_in = S_IDLE;
                  end
               end
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      total_in     = emit ? (total_ff + 32'd1) : total_ff;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         row_valid_ff    <= '0;
         direct_store_ff <= '0;
         pending_ff      <= 1'b0;
         total_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         row_valid_ff    <= row_valid_in;
         direct_store_ff <= direct_store_in;
         pending_ff      <= pending_in;
         total_ff        <= total_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         raw_ff  <= req_raw_sample;
         row_ff  <= req_row_index;
         time_ff <= req_sample_time;
      end
      work_s_ff      <= work_s_in;
      work_chg_ff    <= work_chg_in;
      work_row_ff    <= work_row_in;
      work_direct_ff <= work_direct_in;
      idx_ff         <= idx_in;
      if (emit) begin
         ev_ff        <= ev;
         rsp_time_ff  <= time_ff;
         rsp_count_ff <= total_ff + 32'd1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_key_pressed   = ev_ff.key_pressed;
   assign rsp_key_row       = ev_ff.key_row;
   assign rsp_key_col       = ev_ff.key_col;
   assign rsp_scan_code     = ev_ff.scan_code;
   assign rsp_last_of_run   = ev_ff.last_of_run;
   assign rsp_event_time    = rsp_time_ff;
   assign rsp_events_so_far = rsp_count_ff;

endmodule

// ===== hdl/keyboard_scan_event_generator_top.sv =====
// ----------------------------------------------------------------------------
// keyboard_scan_event_generator_top
// Turns matrix rows, direct line words, i2c event bytes and ps2 bytes into
// key press and release events with a running event count.
//
//  Channel  Direction  Handshake              Carries
//  req_     in         req_valid/req_ready    raw sample, row index, time
//  rsp_     out        rsp_valid/rsp_ready    one key event per transfer
//  csr_     in         csr_valid/csr_ready    register index and write data
//
// When an item is taken its stored row is read from the row memory, and it is
// written back in the cycle after; the direct line word is kept in a register.
// Matrix and direct items then step one bit position per cycle up to the
// highest changed position in use, holding on a changed position while the
// result register waits on rsp_ready. A new item is taken only when idle.
// Reset clears the per-row valid bits, so no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module keyboard_scan_event_generator_top
   import kse_pkg::*;
#(
   parameter int MAX_ROWS     = 16,
   parameter int MAX_COLS     = 16,
   parameter int DIRECT_LINES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_raw_sample,
   input  logic [3:0]  req_row_index,
   input  logic [63:0] req_sample_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_key_pressed,
   output logic [7:0]  rsp_key_row,
   output logic [7:0]  rsp_key_col,
   output logic [7:0]  rsp_scan_code,
   output logic [63:0] rsp_event_time,
   output logic [31:0] rsp_events_so_far,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type cfg;

   kse_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kse_engine #(
      .MAX_ROWS     (MAX_ROWS),
      .MAX_COLS     (MAX_COLS),
      .DIRECT_LINES (DIRECT_LINES)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_raw_sample    (req_raw_sample),
      .req_row_index     (req_row_index),
      .req_sample_time   (req_sample_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_key_pressed   (rsp_key_pressed),
      .rsp_key_row       (rsp_key_row),
      .rsp_key_col       (rsp_key_col),
      .rsp_scan_code     (rsp_scan_code),
      .rsp_event_time    (rsp_event_time),
      .rsp_events_so_far (rsp_events_so_far),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // While an event that is not the last of its run is on offer, the rest of
   // the run is still being scanned and no new item may enter.
   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> !req_ready)
      else $error("new item taken while a run of events is incomplete");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("sequencer not idle right after reset");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyboard_scan_event_generator_top. A tracker class
// keeps its own copy of the registers, stored rows, direct line word, ps2
// break flag and event total, and from every accepted sample it computes the
// key events that must follow. Results are checked field by field in order.
// A short directed pass covers each mode and the edge cases. Random phases
// then walk through register settings under four idle patterns.
// ----------------------------------------------------------------------------
module tb
   import kse_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 400_000;
   localparam int unsigned PHASE_COUNT   = 16;
   localparam int unsigned PHASE_ITEMS   = 22;
   localparam int unsigned QUIET_CYCLES  = 40;

   typedef struct packed {
      logic        pressed;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [7:0]  code;
      logic [63:0] stamp;
      logic [31:0] count;
      logic        last;
   } key_event_type;

   class key_event_tracker;
      cfg_type       regs;
      logic [15:0]   row_image [16];
      logic [31:0]   line_image;
      bit            break_armed;
      logic [31:0]   event_total;
      key_event_type pending_events [$];
      int            errors;
      int            events_checked;

      function void clear();
         regs.interface_mode    = MODE_MATRIX;
         regs.scan_enable       = 1'b1;
         regs.row_count         = 5'd16;
         regs.column_count      = 5'd16;
         regs.matrix_low_active = 1'b0;
         regs.direct_line_count = 6'd32;
         regs.direct_low_active = 1'b0;
         foreach (row_image[i]) row_image[i] = '0;
         line_image     = '0;
         break_armed    = 1'b0;
         event_total    = '0;
         errors         = 0;
         events_checked = 0;
         pending_events.delete();
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            CSR_INTERFACE_MODE:    regs.interface_mode    = val[1:0];
            CSR_SCAN_ENABLE:       regs.scan_enable       = val[0];
            CSR_ROW_COUNT:         regs.row_count         = val[4:0];
            CSR_COLUMN_COUNT:      regs.column_count      = val[4:0];
            CSR_MATRIX_LOW_ACTIVE: regs.matrix_low_active = val[0];
            CSR_DIRECT_LINE_COUNT: regs.direct_line_count = val[5:0];
            CSR_DIRECT_LOW_ACTIVE: regs.direct_low_active = val[0];
            default: ;
         endcase
      endfunction

      function logic [31:0] line_mask(int unsigned n);
         return (n >= 32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << n);
      endfunction

      function void add_event(logic pressed, logic [7:0] row, logic [7:0] col,
                              logic [7:0] code, logic [63:0] stamp);
         key_event_type e;
         event_total = event_total + 32'd1;
         e.pressed = pressed;
         e.row     = row;
         e.col     = col;
         e.code    = code;
         e.stamp   = stamp;
         e.count   = event_total;
         e.last    = 1'b0;
         pending_events.push_back(e);
      endfunction

      // Returns 1 when the block should ignore the sample altogether.
      function bit take_sample(logic [31:0] raw, logic [3:0] ridx, logic [63:0] stamp);
         int unsigned nrows;
         int unsigned ncols;
         int unsigned nlines;
         int unsigned code_less_one;
         int          events_before;
         logic [31:0] word;
         logic [31:0] flips;
         logic [7:0]  b;
         events_before = pending_events.size();
         if (!regs.scan_enable) return 1'b1;
         case (regs.interface_mode)
            MODE_MATRIX: begin
               nrows = (regs.row_count > 16) ? 16 : regs.row_count;
               ncols = (regs.column_count > 16) ? 16 : regs.column_count;
               if (ridx >= nrows) return 1'b1;
               word = {16'h0, raw[15:0]};
               if (regs.matrix_low_active) word = ~word & line_mask(ncols) & 32'h0000_FFFF;
               flips = word ^ {16'h0, row_image[ridx]};
               row_image[ridx] = word[15:0];
               for (int i = 0; i < ncols; i++) begin
                  if (flips[i]) add_event(word[i], {4'h0, ridx}, 8'(i), {ridx, 4'(i)}, stamp);
               end
            end
            MODE_DIRECT: begin
               nlines = (regs.direct_line_count > 32) ? 32 : regs.direct_line_count;
               word = raw;
               if (regs.direct_low_active) word = ~raw & line_mask(nlines);
               flips = word ^ line_image;
               line_image = word;
               for (int i = 0; i < nlines; i++) begin
                  if (flips[i]) add_event(word[i], NO_POSITION, 8'(i),
                                          DIRECT_CODE_BASE | 8'(i), stamp);
               end
            end
            MODE_I2C: begin
               b = raw[7:0];
               if (b == 8'h00) return 1'b1;
               if (b[6:0] == 7'd0) begin
                  add_event(b[7], NO_POSITION, NO_POSITION, 8'h00, stamp);
               end else begin
                  code_less_one = b[6:0] - 1;
                  add_event(b[7], 8'(code_less_one / 10), 8'(code_less_one % 10),
                            {1'b0, b[6:0]}, stamp);
               end
            end
            default: begin
               b = raw[7:0];
               if (b == PS2_BREAK_PREFIX) begin
                  break_armed = 1'b1;
                  return 1'b0;
               end
               add_event(!break_armed, NO_POSITION, NO_POSITION, b, stamp);
               break_armed = 1'b0;
            end
         endcase
         if (pending_events.size() > events_before)
            pending_events[pending_events.size() - 1].last = 1'b1;
         return 1'b0;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 100) $display("ERROR at %0t: %s", $time, msg);
      endtask

      task check_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("event %0d %s: got %0h, expected %0h",
                             events_checked, name, got, want));
      endtask

      task check_event(key_event_type got);
         key_event_type want;
         if (pending_events.size() == 0) begin
            report($sformatf("unexpected event, scan code %02h", got.code));
            return;
         end
         want = pending_events.pop_front();
         events_checked++;
         check_field("key_pressed", got.pressed, want.pressed);
         check_field("key_row", got.row, want.row);
         check_field("key_col", got.col, want.col);
         check_field("scan_code", got.code, want.code);
         check_field("event_time", got.stamp, want.stamp);
         check_field("events_so_far", got.count, want.count);
         check_field("last_of_run", got.last, want.last);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_raw_sample = '0;
   logic [3:0]  req_row_index = '0;
   logic [63:0] req_sample_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_key_pressed;
   logic [7:0]  rsp_key_row;
   logic [7:0]  rsp_key_col;
   logic [7:0]  rsp_scan_code;
   logic [63:0] rsp_event_time;
   logic [31:0] rsp_events_so_far;
   logic        rsp_last_of_run;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   key_event_tracker tracker;
   key_event_type    seen_event;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_stall_pct = 0;
   int unsigned      cycle_count = 0;
   int unsigned      live_samples = 0;
   int unsigned      settings_used = 0;

   keyboard_scan_event_generator_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_raw_sample    (req_raw_sample),
      .req_row_index     (req_row_index),
      .req_sample_time   (req_sample_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_key_pressed   (rsp_key_pressed),
      .rsp_key_row       (rsp_key_row),
      .rsp_key_col       (rsp_key_col),
      .rsp_scan_code     (rsp_scan_code),
      .rsp_event_time    (rsp_event_time),
      .rsp_events_so_far (rsp_events_so_far),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("keyboard_scan_event_generator_top: mismatch");
         $finish;
      end
   end

   // Result side: check the transfer seen at this edge, then pick the next ready.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         seen_event = {rsp_key_pressed, rsp_key_row, rsp_key_col, rsp_scan_code,
                       rsp_event_time, rsp_events_so_far, rsp_last_of_run};
         tracker.check_event(seen_event);
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [63:0] rand_stamp();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] pick_count(int unsigned full, int unsigned top);
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'd1;
         2: return full;
         3: return $urandom_range(top, full + 1);
         default: return $urandom_range(full, 1);
      endcase
   endfunction

   task automatic send_item(logic [31:0] raw, logic [3:0] ridx, logic [63:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_raw_sample  <= raw;
      req_row_index   <= ridx;
      req_sample_time <= stamp;
      do @(posedge clock); while (!req_ready);
      if (!tracker.take_sample(raw, ridx, stamp)) live_samples++;
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, val);
   endtask

   // Registers only change once every expected event is out and the block
   // has had time to finish a sample that produced none.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (tracker.pending_events.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic random_item(logic [1:0] mode);
      logic [31:0] raw;
      logic [63:0] stamp;
      case ($urandom_range(4))
         0: raw = 32'h0;
         1: raw = 32'hFFFF_FFFF;
         2: raw = $urandom & $urandom & $urandom;
         default: raw = $urandom;
      endcase
      if (mode == MODE_I2C && $urandom_range(7) == 0)
         raw[7:0] = $urandom_range(1) ? 8'h80 : 8'h00;
      if (mode == MODE_PS2 && $urandom_range(9) < 3) raw[7:0] = PS2_BREAK_PREFIX;
      case ($urandom_range(15))
         0: stamp = 64'h0;
         1: stamp = 64'hFFFF_FFFF_FFFF_FFFF;
         default: stamp = rand_stamp();
      endcase
      send_item(raw, 4'($urandom_range(15)), stamp);
   endtask

   initial begin
      int unsigned phase;
      logic [1:0]  mode;
      tracker = new;
      tracker.clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: matrix mode at reset settings.
      send_item(32'h0000_FFFF, 4'd0, 64'h0);
      send_item(32'hFFFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(32'h0000_8001, 4'd0, rand_stamp());
      send_item(32'h0000_0000, 4'd15, rand_stamp());

      // Small active-low matrix; row 4 is past the rows in use.
      wait_quiet();
      csr_write(CSR_ROW_COUNT, 32'd4);
      csr_write(CSR_COLUMN_COUNT, 32'd3);
      csr_write(CSR_MATRIX_LOW_ACTIVE, 32'd1);
      csr_valid <= 1'b0;
      send_item(32'h0, 4'd4, rand_stamp());
      send_item(32'h0, 4'd3, rand_stamp());
      send_item(32'hFFFF_FFFA, 4'd3, rand_stamp());

      // No columns in use gives an all-zero mask; then saturated counts.
      wait_quiet();
      csr_write(CSR_COLUMN_COUNT, 32'd0);
      csr_valid <= 1'b0;
      send_item(32'h0, 4'd3, rand_stamp());
      wait_quiet();
      csr_write(CSR_ROW_COUNT, 32'd31);
      csr_write(CSR_COLUMN_COUNT, 32'd31);
      csr_write(CSR_MATRIX_LOW_ACTIVE, 32'd0);
      csr_valid <= 1'b0;
      send_item(32'h1234_ABCD, 4'd9, rand_stamp());

      // Zero rows in use, then scanning switched off.
      wait_quiet();
      csr_write(CSR_ROW_COUNT, 32'd0);
      csr_valid <= 1'b0;
      send_item(32'h0000_5555, 4'd0, rand_stamp());
      wait_quiet();
      csr_write(CSR_ROW_COUNT, 32'd16);
      csr_write(CSR_SCAN_ENABLE, 32'd0);
      csr_valid <= 1'b0;
      send_item(32'h0000_FFFF, 4'd1, rand_stamp());

      // Direct lines.
      wait_quiet();
      csr_write(CSR_SCAN_ENABLE, 32'd1);
      csr_write(CSR_INTERFACE_MODE, MODE_DIRECT);
      csr_valid <= 1'b0;
      send_item(32'hFFFF_FFFF, 4'd7, rand_stamp());
      send_item(32'h8000_0001, 4'd0, rand_stamp());
      wait_quiet();
      csr_write(CSR_DIRECT_LOW_ACTIVE, 32'd1);
      csr_valid <= 1'b0;
      send_item(32'h0, 4'd0, rand_stamp());
      wait_quiet();
      csr_write(CSR_DIRECT_LINE_COUNT, 32'd0);
      csr_valid <= 1'b0;
      send_item(32'h0, 4'd0, rand_stamp());
      wait_quiet();
      csr_write(CSR_DIRECT_LINE_COUNT, 32'd40);
      csr_valid <= 1'b0;
      send_item(32'h7FFF_FFFE, 4'd0, rand_stamp());

      // i2c event bytes: zero, bare press bit, extremes, a mid code.
      wait_quiet();
      csr_write(CSR_INTERFACE_MODE, MODE_I2C);
      csr_valid <= 1'b0;
      send_item(32'hFFFF_FF00, 4'd0, rand_stamp());
      send_item(32'h0000_0080, 4'd0, rand_stamp());
      send_item(32'h0000_00FF, 4'd0, rand_stamp());
      send_item(32'h0000_0001, 4'd0, rand_stamp());
      send_item(32'hABCD_EF8A, 4'd0, rand_stamp());

      // ps2 bytes: a make, a doubled break prefix, the release, extremes.
      wait_quiet();
      csr_write(CSR_INTERFACE_MODE, MODE_PS2);
      csr_valid <= 1'b0;
      send_item(32'h0000_001C, 4'd0, rand_stamp());
      send_item(32'h0000_00F0, 4'd0, rand_stamp());
      send_item(32'h0000_00F0, 4'd0, rand_stamp());
      send_item(32'h0000_001C, 4'd0, rand_stamp());
      send_item(32'h0000_0000, 4'd0, rand_stamp());
      send_item(32'hFFFF_FFFF, 4'd0, rand_stamp());

      // Random phases: every mode meets every idle pattern.
      phase = 0;
      while (phase < PHASE_COUNT) begin
         wait_quiet();
         case ((phase >> 2) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         mode = 2'(phase % 4);
         csr_write(CSR_INTERFACE_MODE, mode);
         csr_write(CSR_SCAN_ENABLE, ($urandom_range(7) != 0));
         csr_write(CSR_ROW_COUNT, pick_count(16, 31));
         csr_write(CSR_COLUMN_COUNT, pick_count(16, 31));
         csr_write(CSR_MATRIX_LOW_ACTIVE, $urandom_range(1));
         csr_write(CSR_DIRECT_LINE_COUNT, pick_count(32, 63));
         csr_write(CSR_DIRECT_LOW_ACTIVE, $urandom_range(1));
         csr_valid <= 1'b0;
         settings_used++;
         repeat (PHASE_ITEMS) random_item(mode);
         phase++;
      end

      wait_quiet();
      $display("Checked %0d key events from %0d live samples across %0d random settings,",
               tracker.events_checked, live_samples, settings_used);
      $display("in matrix, direct, i2c and ps2 modes under four idle patterns.");
      if (tracker.errors == 0 && tracker.pending_events.size() == 0) begin
         $display("keyboard_scan_event_generator_top: match");
      end else begin
         $display("keyboard_scan_event_generator_top: mismatch");
      end
      $finish;
   end

endmodule
